[rtl/positional_insert_erase_array_core_assert.svh]
// Assertion macros for the positional insert/erase array core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POSITIONAL_INSERT_ERASE_ARRAY_CORE_ASSERT_SVH
`define POSITIONAL_INSERT_ERASE_ARRAY_CORE_ASSERT_SVH

// check a property at every clock edge outside reset
`define PIEA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every clock edge, reset included
`define PIEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/piea_pkg.sv]
// Package for the positional insert/erase array core: operation, status and cell codes.
// Used by piea_cell and positional_insert_erase_array_core; no dependencies.
`timescale 1ns / 1ps

package piea_pkg;

  localparam int ValueW  = 32;
  localparam int FuncW   = 3;
  localparam int PosW    = 5;
  localparam int CountW  = 5;
  localparam int StatusW = 2;

  typedef enum logic [FuncW-1:0] {
    FN_APPEND  = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_INSERT  = 3'd2,
    FN_ERASE   = 3'd3,
    FN_READ    = 3'd4,
    FN_CLEAR   = 3'd5
  } func_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_t;

endpackage

[rtl/piea_cell.sv]
// One storage cell of the array row: holds one word, loads, or takes a neighbor's word.
// Depends on piea_pkg.
`timescale 1ns / 1ps

module piea_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  piea_pkg::cell_op_t                op,
  input  logic [IW-1:0]                     pos,
  input  logic signed [piea_pkg::ValueW-1:0] new_value,
  input  logic signed [piea_pkg::ValueW-1:0] below_data,
  input  logic signed [piea_pkg::ValueW-1:0] above_data,
  output logic signed [piea_pkg::ValueW-1:0] data
);
  import piea_pkg::*;

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic signed [ValueW-1:0] data_r;
  logic signed [ValueW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CELL_HOLD: begin
        data_nxt = data_r;
      end
      CELL_INSERT: begin
        if (MyIdx == pos) begin
          data_nxt = new_value;
        end else if (MyIdx > pos) begin
          data_nxt = below_data;
        end
      end
      CELL_ERASE: begin
        if (MyIdx >= pos) begin
          data_nxt = above_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[rtl/positional_insert_erase_array_core.sv]
// Top level of the positional insert/erase array: fill count, command decode and cell row.
// Depends on piea_pkg, piea_cell and positional_insert_erase_array_core_assert.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   input    | start, busy        | in_func, in_position, in_value
//   result   | out_valid (strobe) | out_read_value, out_count_after, out_status
//
// Every cell shifts in parallel, so each command completes
// in the cycle of its transfer and its result strobes in the next cycle.
// busy stays low; a new command may follow every cycle.
// Synchronous active-low reset clears the fill count and the strobe; cell words
// are undefined until written. The receiver cannot stall.
`timescale 1ns / 1ps

module positional_insert_erase_array_core #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [piea_pkg::FuncW-1:0]          in_func,
  input  logic [piea_pkg::PosW-1:0]           in_position,
  input  logic signed [piea_pkg::ValueW-1:0]  in_value,
  output logic                                out_valid,
  output logic signed [piea_pkg::ValueW-1:0]  out_read_value,
  output logic [piea_pkg::CountW-1:0]         out_count_after,
  output logic [piea_pkg::StatusW-1:0]        out_status
);
  import piea_pkg::*;
  `include "positional_insert_erase_array_core_assert.svh"

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [CW-1:0]           fill_count_r;
  logic [CW-1:0]           fill_count_nxt;
  logic                    out_valid_r;
  logic signed [ValueW-1:0] read_value_r;
  logic signed [ValueW-1:0] read_value_nxt;
  status_t                 status_r;
  status_t                 status_nxt;

  cell_op_t                cell_op;
  logic [IW-1:0]           cell_pos;
  logic signed [ValueW-1:0] cell_data [DEPTH];

  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic [WW-1:0]           pos_w;
  logic [WW-1:0]           cnt_w;
  logic [IW-1:0]           pos_idx;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (fill_count_r == FullCount);
  assign is_empty = (fill_count_r == '0);
  assign pos_w    = WW'(in_position);
  assign cnt_w    = WW'(fill_count_r);
  assign pos_idx  = IW'(pos_w);

  always_comb begin
    fill_count_nxt = fill_count_r;
    read_value_nxt = '0;
    status_nxt     = ST_OK;
    cell_op        = CELL_HOLD;
    cell_pos       = pos_idx;
    if (accept) begin
      unique case (func_t'(in_func))
        FN_APPEND: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            cell_op        = CELL_INSERT;
            cell_pos       = IW'(fill_count_r);
            fill_count_nxt = fill_count_r + CW'(1);
          end
        end
        FN_REMOVE: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            fill_count_nxt = fill_count_r - CW'(1);
          end
        end
        FN_INSERT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else if (pos_w > cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            cell_op        = CELL_INSERT;
            fill_count_nxt = fill_count_r + CW'(1);
          end
        end
        FN_ERASE: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (pos_w >= cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            cell_op        = CELL_ERASE;
            fill_count_nxt = fill_count_r - CW'(1);
          end
        end
        FN_READ: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (pos_w >= cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            read_value_nxt = cell_data[pos_idx];
          end
        end
        FN_CLEAR: begin
          fill_count_nxt = '0;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ValueW-1:0] below;
    logic signed [ValueW-1:0] above;
    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign above = '0;
    end else begin : g_mid_hi
      assign above = cell_data[g+1];
    end
    piea_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .pos        (cell_pos),
      .new_value  (in_value),
      .below_data (below),
      .above_data (above),
      .data       (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= accept;
    end
    read_value_r <= read_value_nxt;
    status_r     <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = read_value_r;
  assign out_count_after = CountW'(fill_count_r);
  assign out_status      = status_r;

  `PIEA_ASSERT_ALWAYS(a_reset_clears_strobe, clk, !rst_n |=> !out_valid, "strobe after reset")
  `PIEA_ASSERT(a_count_bound, clk, rst_n, fill_count_r <= FullCount, "fill count above depth")
  `PIEA_ASSERT(a_result_follows, clk, rst_n, accept |=> out_valid, "transfer without result")
  `PIEA_ASSERT(a_refused_keeps_count, clk, rst_n, out_valid && (status_r != ST_OK) |-> fill_count_r == $past(fill_count_r), "refused command changed count")
  `PIEA_ASSERT(a_refused_reads_zero, clk, rst_n, out_valid && (status_r != ST_OK) |-> read_value_r == '0, "refused command returned data")

endmodule

[tb/positional_insert_erase_array_checker.sv]
// Checker for the positional insert/erase array core: keeps its own copy of the array,
// predicts one result per accepted command and compares it with the result strobe.
// Depends on piea_pkg.
`timescale 1ns / 1ps

module positional_insert_erase_array_checker #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [piea_pkg::FuncW-1:0]          in_func,
  input  logic [piea_pkg::PosW-1:0]           in_position,
  input  logic signed [piea_pkg::ValueW-1:0]  in_value,
  input  logic                                out_valid,
  input  logic signed [piea_pkg::ValueW-1:0]  out_read_value,
  input  logic [piea_pkg::CountW-1:0]         out_count_after,
  input  logic [piea_pkg::StatusW-1:0]        out_status,
  output int                                  failures,
  output int                                  outstanding
);
  import piea_pkg::*;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic [CountW-1:0]        count_after;
    status_t                  status;
  } array_result_t;

  logic signed [ValueW-1:0] cells [DEPTH];
  int                       fill_level;
  array_result_t            pending_results [$];
  array_result_t            oldest;

  initial failures = 0;

  task automatic report_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic enqueue_result(input array_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  function automatic array_result_t apply_command(input logic [FuncW-1:0] f,
                                                  input logic [PosW-1:0] p,
                                                  input logic signed [ValueW-1:0] v);
    array_result_t r;
    int            i;
    r.read_value = '0;
    r.status     = ST_OK;
    case (f)
      FN_APPEND: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cells[fill_level] = v;
          fill_level++;
        end
      end
      FN_REMOVE: begin
        if (fill_level == 0) r.status = ST_EMPTY;
        else fill_level--;
      end
      FN_INSERT: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(p) > fill_level) begin
          r.status = ST_RANGE;
        end else begin
          for (i = fill_level; i > int'(p); i--) cells[i] = cells[i-1];
          cells[p] = v;
          fill_level++;
        end
      end
      FN_ERASE: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(p) >= fill_level) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(p); i + 1 < fill_level; i++) cells[i] = cells[i+1];
          fill_level--;
        end
      end
      FN_READ: begin
        if (fill_level == 0) r.status = ST_EMPTY;
        else if (int'(p) >= fill_level) r.status = ST_RANGE;
        else r.read_value = cells[p];
      end
      FN_CLEAR: fill_level = 0;
      default: ;
    endcase
    r.count_after = CountW'(fill_level);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_level = 0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result with no command outstanding (value %0h count %0d)",
                                 out_read_value, out_count_after));
        end else begin
          oldest = pending_results.pop_front();
          if (out_read_value !== oldest.read_value)
            report_error($sformatf("read_value got %0h expected %0h",
                                   out_read_value, oldest.read_value));
          if (out_count_after !== oldest.count_after)
            report_error($sformatf("count_after got %0d expected %0d",
                                   out_count_after, oldest.count_after));
          if (out_status !== oldest.status)
            report_error($sformatf("status got %0d expected %0d",
                                   out_status, oldest.status));
        end
      end
      if (start && !busy)
        enqueue_result(apply_command(in_func, in_position, in_value));
      outstanding <= pending_results.size();
    end
  end

endmodule

[tb/positional_insert_erase_array_core_test.sv]
// Top of the array core test: clock, reset, directed and random command stimulus, verdict.
// Depends on piea_pkg, positional_insert_erase_array_core and the array checker.
`timescale 1ns / 1ps

module positional_insert_erase_array_core_test;
  import piea_pkg::*;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 200;
  localparam int RANDOM_CMDS = 600;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [FuncW-1:0]         in_func;
  logic [PosW-1:0]          in_position;
  logic signed [ValueW-1:0] in_value;
  logic                     out_valid;
  logic signed [ValueW-1:0] out_read_value;
  logic [CountW-1:0]        out_count_after;
  logic [StatusW-1:0]       out_status;
  int                       failures;
  int                       outstanding;

  int level;
  int commands;
  int full_hits;
  int empty_hits;
  int stall_cycles;
  bit idle_on;

  positional_insert_erase_array_core #(.DEPTH(DEPTH)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_count_after (out_count_after),
    .out_status      (out_status)
  );

  positional_insert_erase_array_checker #(.DEPTH(DEPTH)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_count_after (out_count_after),
    .out_status      (out_status),
    .failures        (failures),
    .outstanding     (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic signed [ValueW-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // hold start between back-to-back transfers; lower it only ahead of a gap
  task automatic send_command(input logic [FuncW-1:0] f, input logic [PosW-1:0] p,
                              input logic signed [ValueW-1:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= f;
    in_position <= p;
    in_value    <= v;
    do @(posedge clk); while (busy);
    commands++;
    if (level == DEPTH) full_hits++;
    if (level == 0) empty_hits++;
    case (f)
      FN_APPEND: if (level < DEPTH) level++;
      FN_REMOVE: if (level > 0) level--;
      FN_INSERT: if (level < DEPTH && int'(p) <= level) level++;
      FN_ERASE:  if (level > 0 && int'(p) < level) level--;
      FN_CLEAR:  level = 0;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int               n;
    int               r;
    int               k;
    int               directed;
    bit               growing;
    logic [FuncW-1:0] op;
    logic [PosW-1:0]  pos;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_func     <= '0;
    in_position <= '0;
    in_value    <= '0;
    level        = 0;
    commands     = 0;
    full_hits    = 0;
    empty_hits   = 0;
    idle_on      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(FN_READ, 0, 0);
    send_command(FN_REMOVE, 0, 0);
    send_command(FN_ERASE, 0, 0);
    send_command(FN_INSERT, 1, 5);
    send_command(FN_INSERT, 0, 32'sh7fffffff);
    send_command(FN_APPEND, 0, 32'sh80000000);
    send_command(FN_INSERT, 1, -1);
    send_command(FN_READ, 1, 0);
    send_command(FN_READ, 3, 0);
    send_command(FN_ERASE, 3, 0);
    send_command(FN_ERASE, 0, 0);
    send_command(3'd6, 5'd31, -1);
    send_command(3'd7, 0, 0);
    send_command(FN_CLEAR, 0, 0);
    send_command(FN_CLEAR, 0, 0);
    for (n = 0; n < DEPTH; n++) begin
      if (n % 3 == 0) send_command(FN_APPEND, 0, random_word());
      else if (n % 3 == 1) send_command(FN_INSERT, 0, random_word());
      else send_command(FN_INSERT, 5'(level), random_word());
    end
    send_command(FN_APPEND, 0, 1);
    send_command(FN_INSERT, 5'd31, 2);
    send_command(FN_READ, 15, 0);
    send_command(FN_READ, 16, 0);
    directed = commands;

    growing = 1'b1;
    for (n = 0; n < RANDOM_CMDS; n++) begin
      if (n == 0) idle_on = 1'b1;
      else if (n == 100) idle_on = 1'b0;
      else if (n % 100 == 0) idle_on = 1'($urandom_range(0, 1));
      if (n == 300 || $urandom_range(0, 99) == 0) drain_results();
      if (level == DEPTH) growing = 1'b0;
      else if (level == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 3) growing = !growing;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        op  = FuncW'($urandom_range(0, 7));
        pos = PosW'($urandom_range(0, 31));
      end else if (r < 10) begin
        op  = FN_CLEAR;
        pos = PosW'($urandom_range(0, 16));
      end else begin
        k = $urandom_range(0, 99);
        if (growing)
          op = k < 35 ? FN_APPEND : k < 70 ? FN_INSERT : k < 85 ? FN_READ :
               k < 93 ? FN_ERASE : FN_REMOVE;
        else
          op = k < 35 ? FN_REMOVE : k < 70 ? FN_ERASE : k < 85 ? FN_READ :
               k < 93 ? FN_INSERT : FN_APPEND;
        if ($urandom_range(0, 9) == 0) pos = PosW'($urandom_range(level, 16));
        else if (op == FN_INSERT) pos = PosW'($urandom_range(0, level));
        else pos = level > 0 ? PosW'($urandom_range(0, level - 1)) : '0;
      end
      send_command(op, pos, random_word());
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d commands (%0d directed), %0d issued at full, %0d on empty",
             commands, directed, full_hits, empty_hits);
    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", failures, outstanding);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
